@@ design/swfg_pkg.sv @@
package swfg_pkg;

    localparam int unsigned CFG_INDEX_WIDTH = 8;
    localparam int unsigned CFG_DATA_WIDTH  = 32;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LEAD      = 8'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_HOST_LOW  = 8'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_HOST_HIGH = 8'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ACK       = 8'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_GAP       = 8'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ZERO      = 8'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ONE       = 8'd6;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IDLE      = 8'd7;

    localparam logic [29:0] LEAD_RESET      = 30'd200000;
    localparam logic [19:0] HOST_LOW_RESET  = 20'd2000;
    localparam logic [15:0] HOST_HIGH_RESET = 16'd30;
    localparam logic [15:0] ACK_RESET       = 16'd80;
    localparam logic [15:0] GAP_RESET       = 16'd50;
    localparam logic [15:0] ZERO_RESET      = 16'd25;
    localparam logic [15:0] ONE_RESET       = 16'd72;
    localparam logic [29:0] IDLE_RESET      = 30'd2000000;

    localparam int unsigned FRAME_BITS = 40;

    typedef struct packed {
        logic [29:0] lead_samples;
        logic [19:0] host_low_samples;
        logic [15:0] host_high_samples;
        logic [15:0] ack_samples;
        logic [15:0] gap_samples;
        logic [15:0] zero_samples;
        logic [15:0] one_samples;
        logic [29:0] idle_samples;
    } swfg_cfg_t;

endpackage

@@ design/swfg_sample_if.sv @@
interface swfg_sample_if;
    logic        valid;
    logic        ready;
    logic        start_req;
    logic [15:0] humidity;
    logic [15:0] temperature;

    modport source (output valid, output start_req, output humidity, output temperature,
                    input ready);
    modport sink   (input valid, input start_req, input humidity, input temperature,
                    output ready);
endinterface

@@ design/swfg_level_if.sv @@
interface swfg_level_if;
    logic valid;
    logic ready;
    logic line_level;
    logic busy_res;
    logic frame_end;

    modport source (output valid, output line_level, output busy_res, output frame_end,
                    input ready);
    modport sink   (input valid, input line_level, input busy_res, input frame_end,
                    output ready);
endinterface

@@ design/swfg_cfg_if.sv @@
interface swfg_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [swfg_pkg::CFG_INDEX_WIDTH-1:0] index;
    logic [swfg_pkg::CFG_DATA_WIDTH-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/swfg_cfg.sv @@
module swfg_cfg (
    input  logic               clk,
    input  logic               rst_n,
    swfg_cfg_if.sink           cfg,
    output swfg_pkg::swfg_cfg_t regs
);

    swfg_pkg::swfg_cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.lead_samples      <= swfg_pkg::LEAD_RESET;
            regs_reg.host_low_samples  <= swfg_pkg::HOST_LOW_RESET;
            regs_reg.host_high_samples <= swfg_pkg::HOST_HIGH_RESET;
            regs_reg.ack_samples       <= swfg_pkg::ACK_RESET;
            regs_reg.gap_samples       <= swfg_pkg::GAP_RESET;
            regs_reg.zero_samples      <= swfg_pkg::ZERO_RESET;
            regs_reg.one_samples       <= swfg_pkg::ONE_RESET;
            regs_reg.idle_samples      <= swfg_pkg::IDLE_RESET;
        end
        else if (cfg.valid)
        begin
            // Writes to indexes beyond the register list are dropped.
            case (cfg.index)
                swfg_pkg::CFG_LEAD:      regs_reg.lead_samples      <= cfg.data[29:0];
                swfg_pkg::CFG_HOST_LOW:  regs_reg.host_low_samples  <= cfg.data[19:0];
                swfg_pkg::CFG_HOST_HIGH: regs_reg.host_high_samples <= cfg.data[15:0];
                swfg_pkg::CFG_ACK:       regs_reg.ack_samples       <= cfg.data[15:0];
                swfg_pkg::CFG_GAP:       regs_reg.gap_samples       <= cfg.data[15:0];
                swfg_pkg::CFG_ZERO:      regs_reg.zero_samples      <= cfg.data[15:0];
                swfg_pkg::CFG_ONE:       regs_reg.one_samples       <= cfg.data[15:0];
                swfg_pkg::CFG_IDLE:      regs_reg.idle_samples      <= cfg.data[29:0];
                default: ;
            endcase
        end
    end

endmodule

@@ design/swfg_frame.sv @@
module swfg_frame #(
    parameter int unsigned COUNT_WIDTH = 30
) (
    input  logic                clk,
    input  logic                rst_n,
    input  swfg_pkg::swfg_cfg_t regs,
    swfg_sample_if.sink         sample_in,
    swfg_level_if.source        level_out
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_LEAD,
        PH_HLOW,
        PH_HHIGH,
        PH_ACKL,
        PH_ACKH,
        PH_GAP0,
        PH_BITH,
        PH_BITL,
        PH_CLOSE,
        PH_PAD
    } phase_t;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = '1;
    localparam logic [5:0]             BITS_END = 6'(swfg_pkg::FRAME_BITS);

    function automatic logic [COUNT_WIDTH-1:0] fit_len(input logic [29:0] v);
        logic [31:0] wide;
        wide = 32'(v);
        if (wide > 32'(CNT_MAX))
            return CNT_MAX;
        else
            return wide[COUNT_WIDTH-1:0];
    endfunction

    function automatic logic [29:0] at_least_one(input logic [29:0] v);
        return (v == 30'd0) ? 30'd1 : v;
    endfunction

    // Input register
    logic        in_valid_reg;
    logic        start_req_reg;
    logic [15:0] humidity_reg;
    logic [15:0] temperature_reg;

    // Frame state
    phase_t                 phase_reg,     phase_next;
    logic [COUNT_WIDTH-1:0] count_reg,     count_next;
    logic [5:0]             bit_count_reg, bit_count_next;
    logic [39:0]            bits_reg,      bits_next;

    // Result register
    logic out_valid_reg;
    logic line_reg, line_next;
    logic busy_reg, busy_next;
    logic end_reg,  end_next;

    logic                   adv;
    logic                   in_ready;
    phase_t                 cur_phase;
    logic [COUNT_WIDTH-1:0] cur_count;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic [COUNT_WIDTH-1:0] cur_len;
    logic [5:0]             cur_bit_count;
    logic [5:0]             bit_count_inc;
    logic [39:0]            cur_bits;
    logic [7:0]             checksum;
    logic [COUNT_WIDTH-1:0] lead_len;
    logic [COUNT_WIDTH-1:0] idle_len;

    assign adv      = in_valid_reg && (!out_valid_reg || level_out.ready);
    assign in_ready = !in_valid_reg || adv;

    assign sample_in.ready      = in_ready;
    assign level_out.valid      = out_valid_reg;
    assign level_out.line_level = line_reg;
    assign level_out.busy_res   = busy_reg;
    assign level_out.frame_end  = end_reg;

    assign checksum = humidity_reg[15:8] + humidity_reg[7:0]
                    + temperature_reg[15:8] + temperature_reg[7:0];
    assign lead_len = fit_len(regs.lead_samples);
    assign idle_len = fit_len(regs.idle_samples);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= sample_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && sample_in.valid)
        begin
            start_req_reg   <= sample_in.start_req;
            humidity_reg    <= sample_in.humidity;
            temperature_reg <= sample_in.temperature;
        end
    end

    // A start taken while idle makes this tick the first sample of the frame.
    always_comb
    begin
        cur_phase     = phase_reg;
        cur_count     = count_reg;
        cur_bit_count = bit_count_reg;
        cur_bits      = bits_reg;
        if (phase_reg == PH_IDLE && start_req_reg)
        begin
            cur_bits      = {humidity_reg, temperature_reg, checksum};
            cur_bit_count = 6'd0;
            cur_count     = '0;
            cur_phase     = (lead_len == '0) ? PH_HLOW : PH_LEAD;
        end
    end

    always_comb
    begin
        case (cur_phase)
            PH_LEAD:  cur_len = lead_len;
            PH_HLOW:  cur_len = fit_len(at_least_one(30'(regs.host_low_samples)));
            PH_HHIGH: cur_len = fit_len(at_least_one(30'(regs.host_high_samples)));
            PH_ACKL,
            PH_ACKH:  cur_len = fit_len(at_least_one(30'(regs.ack_samples)));
            PH_GAP0,
            PH_BITL,
            PH_CLOSE: cur_len = fit_len(at_least_one(30'(regs.gap_samples)));
            PH_BITH:  cur_len = cur_bits[39]
                              ? fit_len(at_least_one(30'(regs.one_samples)))
                              : fit_len(at_least_one(30'(regs.zero_samples)));
            PH_PAD:   cur_len = idle_len;
            default:  cur_len = '0;
        endcase
    end

    assign cnt_inc       = cur_count + 1'b1;
    assign bit_count_inc = cur_bit_count + 6'd1;

    always_comb
    begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        bit_count_next = bit_count_reg;
        bits_next      = bits_reg;
        line_next      = 1'b1;
        busy_next      = 1'b0;
        end_next       = 1'b0;
        if (cur_phase != PH_IDLE)
        begin
            line_next      = !(cur_phase inside {PH_HLOW, PH_ACKL, PH_GAP0, PH_BITL});
            busy_next      = 1'b1;
            bits_next      = cur_bits;
            bit_count_next = cur_bit_count;
            phase_next     = cur_phase;
            count_next     = cnt_inc;
            if (cnt_inc >= cur_len)
            begin
                count_next = '0;
                case (cur_phase)
                    PH_LEAD:  phase_next = PH_HLOW;
                    PH_HLOW:  phase_next = PH_HHIGH;
                    PH_HHIGH: phase_next = PH_ACKL;
                    PH_ACKL:  phase_next = PH_ACKH;
                    PH_ACKH:  phase_next = PH_GAP0;
                    PH_GAP0:  phase_next = PH_BITH;
                    PH_BITH:  phase_next = PH_BITL;
                    PH_BITL:
                    begin
                        // The frame word shifts so that the bit on air is always the MSB.
                        bits_next      = {cur_bits[38:0], 1'b0};
                        bit_count_next = bit_count_inc;
                        phase_next     = (bit_count_inc == BITS_END) ? PH_CLOSE : PH_BITH;
                    end
                    PH_CLOSE: phase_next = (idle_len == '0) ? PH_IDLE : PH_PAD;
                    default:  phase_next = PH_IDLE;
                endcase
            end
            end_next = (phase_next == PH_IDLE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
            bit_count_reg <= 6'd0;
            bits_reg      <= 40'd0;
            out_valid_reg <= 1'b0;
            line_reg      <= 1'b1;
            busy_reg      <= 1'b0;
            end_reg       <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                phase_reg     <= phase_next;
                count_reg     <= count_next;
                bit_count_reg <= bit_count_next;
                bits_reg      <= bits_next;
                line_reg      <= line_next;
                busy_reg      <= busy_next;
                end_reg       <= end_next;
                out_valid_reg <= 1'b1;
            end
            else if (level_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_end_is_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && end_reg |-> busy_reg)
        else $error("frame end flagged on a sample outside a frame");

    a_bit_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_count_reg <= BITS_END)
        else $error("bit counter ran past the frame length");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid_reg && !level_out.ready)
        else $error("input stalled while the result register could drain");

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(phase_reg) && $stable(count_reg) && $stable(bits_reg))
        else $error("frame state moved without an item being processed");

    a_idle_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> count_reg == '0)
        else $error("segment counter not cleared while idle");

endmodule

@@ design/single_wire_sensor_frame_generator.sv @@
// Pulse-width bit frame generator for a single-wire sensor line. Every item on
// sample_in is one sample tick and yields exactly one item on level_out with the
// wire level, a busy flag and a frame-end flag. The block takes one item per clock
// cycle while level_out is not stalling; each item passes an input register, the step
// logic and a result register, whose contents are offered on level_out. A start request
// accepted while idle latches humidity and temperature and begins the frame on that
// same sample. Segment lengths come from the configuration registers on cfg, which
// always accepts writes; write them only while no frame is running. Lengths are
// counted in a COUNT_WIDTH bit counter and saturate at its maximum.
module single_wire_sensor_frame_generator #(
    parameter int unsigned COUNT_WIDTH = 30
) (
    input  logic         clk,
    input  logic         rst_n,
    swfg_sample_if.sink  sample_in,
    swfg_level_if.source level_out,
    swfg_cfg_if.sink     cfg
);

    swfg_pkg::swfg_cfg_t regs;

    swfg_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    swfg_frame #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .regs      (regs),
        .sample_in (sample_in),
        .level_out (level_out)
    );

endmodule
